FILE: rtl/sorted_integer_set_assert.svh
`ifndef SORTED_INTEGER_SET_ASSERT_SVH
`define SORTED_INTEGER_SET_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define SIS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define SIS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/sis_pkg.sv
package sis_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int VALUE_W      = 32;
  localparam int POSITION_W   = 6;
  localparam int COUNT_W      = 7;

  localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;

  typedef enum logic [1:0] {
    KIND_INSERT   = 2'd0,
    KIND_REMOVE   = 2'd1,
    KIND_CONTAINS = 2'd2,
    KIND_CLEAR    = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_FOUND     = 3'd1,
    ST_REMOVED   = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4,
    ST_CLEARED   = 3'd5
  } status_t;

  typedef struct packed {
    kind_t                     kind;
    logic signed [VALUE_W-1:0] value;
  } item_t;

  typedef struct packed {
    status_t                   status;
    logic [POSITION_W-1:0]     position;
    logic [COUNT_W-1:0]        count;
    logic signed [VALUE_W-1:0] minimum;
  } result_t;

  // Broadcast from the controller to every cell of the chain.
  typedef struct packed {
    logic                      cmp;
    logic                      ins;
    logic                      rem;
    logic signed [VALUE_W-1:0] value;
  } ctrl_t;

endpackage

FILE: rtl/sis_cell.sv
module sis_cell (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                valid,
  input  sis_pkg::ctrl_t                      ctrl,
  input  logic                                prev_lt,
  input  logic signed [sis_pkg::VALUE_W-1:0]  prev_entry,
  input  logic signed [sis_pkg::VALUE_W-1:0]  next_entry,
  output logic signed [sis_pkg::VALUE_W-1:0]  entry,
  output logic                                lt,
  output logic                                eq
);
  import sis_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      lt <= 1'b0;
      eq <= 1'b0;
    end else if (ctrl.cmp) begin
      lt <= valid && (entry < ctrl.value);
      eq <= valid && (entry == ctrl.value);
    end
  end

  // Cells at or above the insertion point move up by one; the first of them
  // takes the new value. On removal they take the entry above instead.
  always_ff @(posedge clk) begin
    if (ctrl.ins && !lt) begin
      entry <= prev_lt ? ctrl.value : prev_entry;
    end else if (ctrl.rem && !lt) begin
      entry <= next_entry;
    end
  end

endmodule

FILE: rtl/sorted_integer_set.sv
// Channel   Ports               Handshake
// item      item.kind/value     accepted when start && !busy
// result    result.*            valid for one cycle while strobe is high
//
// For each item, every cell compares its entry with the value in the accept
// cycle, and the chain shifts one place in the following cycle.
// The result shows in the cycle after that, while the next item may already enter.
// Reset clears the entry count, busy, strobe and the compare flags, not the cell
// entries; those need no clearing pass. The result side cannot stall, so strobe is never held.
module sorted_integer_set #(
  parameter int CAPACITY = sis_pkg::CAPACITY_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  sis_pkg::item_t   item,
  output logic             strobe,
  output sis_pkg::result_t result
);
  import sis_pkg::*;

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic [CW-1:0]              count;
  logic [CW-1:0]              count_next;
  kind_t                      kind_reg;
  logic signed [VALUE_W-1:0]  value_reg;
  status_t                    status_reg;
  status_t                    status_next;
  logic [IW-1:0]              pos_reg;
  logic [IW-1:0]              pos_next;
  logic [IW-1:0]              pos_idx;
  logic                       found;
  logic                       full;
  ctrl_t                      ctrl;

  logic signed [VALUE_W-1:0]  entry_w [CAPACITY];
  logic [CAPACITY-1:0]        lt_w;
  logic [CAPACITY-1:0]        eq_w;

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      sis_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .valid      (CW'(g) < count),
        .ctrl       (ctrl),
        .prev_lt    ((g == 0) ? 1'b1 : lt_w[(g == 0) ? 0 : g - 1]),
        .prev_entry ((g == 0) ? ctrl.value : entry_w[(g == 0) ? 0 : g - 1]),
        .next_entry ((g == CAPACITY - 1) ? entry_w[g]
                                         : entry_w[(g == CAPACITY - 1) ? g : g + 1]),
        .entry      (entry_w[g]),
        .lt         (lt_w[g]),
        .eq         (eq_w[g])
      );
    end
  endgenerate

  // The less-than flags form a thermometer; its edge is the sorted position.
  always_comb begin
    pos_idx = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (!lt_w[i] && (i == 0 || lt_w[(i == 0) ? 0 : i - 1])) begin
        pos_idx = pos_idx | IW'(i);
      end
    end
  end

  assign found = |eq_w;
  assign full  = (count == CW'(CAPACITY));

  always_comb begin
    count_next  = count;
    status_next = ST_NOT_FOUND;
    pos_next    = '0;
    ctrl.cmp    = start && !busy;
    ctrl.ins    = 1'b0;
    ctrl.rem    = 1'b0;
    ctrl.value  = busy ? value_reg : item.value;
    case (kind_reg)
      KIND_INSERT: begin
        if (found) begin
          status_next = ST_FOUND;
          pos_next    = pos_idx;
        end else if (full) begin
          status_next = ST_FULL;
        end else begin
          status_next = ST_INSERTED;
          pos_next    = pos_idx;
          count_next  = count + CW'(1);
          ctrl.ins    = busy;
        end
      end
      KIND_REMOVE: begin
        if (found) begin
          status_next = ST_REMOVED;
          pos_next    = pos_idx;
          count_next  = count - CW'(1);
          ctrl.rem    = busy;
        end
      end
      KIND_CONTAINS: begin
        if (found) begin
          status_next = ST_FOUND;
          pos_next    = pos_idx;
        end
      end
      KIND_CLEAR: begin
        status_next = ST_CLEARED;
        count_next  = '0;
      end
      default: begin
        status_next = ST_NOT_FOUND;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      strobe <= 1'b0;
      count  <= '0;
    end else begin
      strobe <= busy;
      if (busy) begin
        busy  <= 1'b0;
        count <= count_next;
      end else if (start) begin
        busy <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      kind_reg  <= item.kind;
      value_reg <= item.value;
    end
    if (busy) begin
      status_reg <= status_next;
      pos_reg    <= pos_next;
    end
  end

  always_comb begin
    result.status   = status_reg;
    result.position = POSITION_W'({{POSITION_W{1'b0}}, pos_reg});
    result.count    = COUNT_W'({{COUNT_W{1'b0}}, count});
    result.minimum  = (count != '0) ? entry_w[0] : VALUE_MAX;
  end

`include "sorted_integer_set_assert.svh"

  `SIS_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy, "accept did not raise busy")
  `SIS_ASSERT_NEXT(a_busy_strobe, clk, rst, busy, strobe && !busy, "apply cycle gave no result")
  `SIS_ASSERT_NOW(a_count_cap, clk, rst, strobe, count <= CW'(CAPACITY), "count above capacity")
  `SIS_ASSERT_NOW(a_clear_empty, clk, rst, strobe && result.status == ST_CLEARED,
                  count == '0, "clear left entries")

endmodule
